>>> src/tccw_pkg.sv
// Shared constants for the character-cell text console writer.
package tccw_pkg;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  localparam logic [7:0]  ATTR_RESET = 8'h0F;
  localparam logic [15:0] CELL_RESET = 16'h0F20;

endpackage

>>> src/text_console_cell_writer_top.sv
// Top level of the character-cell text console writer with its screen memory.
//
// Usage: each input beat carries func_i, char_code_i and cell_index_i and is
// taken when in_valid_i is high and in_stall_o is low. Every input beat gives
// exactly one output beat with the cell read (zero unless an in-range read) and
// the cursor row and column after the operation. cfg_we_i writes cfg_wdata_i
// into the attribute byte used for put characters and for blanked cells.
// Timing: the screen lives in one memory with one write and one registered
// read port. For put, read and control codes the accept cycle does the memory
// access, then the S_DONE state loads the output register once it is free.
// Clear writes one cell per cycle. A scroll copies one cell per cycle through
// the read port and writes it one row up, blanking the bottom row; a put or
// newline that leaves the last row scrolls.
// Reset: the cursor homes and the attribute becomes 0x0F, then a clearing pass
// fills the screen with 0x0F20; in_stall_o stays high during that pass, while
// configuration writes work.
// Stall: a new beat is accepted while an earlier result is still held by a
// stalled receiver; that beat's result then waits until the output frees.
module text_console_cell_writer_top #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cell_value_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o
);

  localparam int Cols  = SCREEN_COLUMNS;
  localparam int Rows  = SCREEN_ROWS;
  localparam int Cells = Cols * Rows;
  localparam int AW    = $clog2(Cells);
  localparam int RW    = $clog2(Rows);
  localparam int CW    = $clog2(Cols);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [15:0] mem_q [Cells];
  logic [15:0] mem_rdata_q;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;
  logic [7:0]    attr_q;
  logic          rd_pend_q, rd_pend_d;

  logic          out_valid_q;
  logic [15:0]   out_value_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [15:0]   blank;
  logic [AW-1:0] cur_addr;
  logic          sweep_last;
  logic          out_free;
  logic          adv_row;
  logic [AW:0]   scroll_next;

  assign blank       = {attr_q, tccw_pkg::CHAR_SPACE};
  assign cur_addr    = base_q + AW'(col_q);
  assign sweep_last  = (sweep_q == AW'(Cells - 1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scroll_next = (AW + 1)'(sweep_q) + (AW + 1)'(Cols + 1);

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    row_d     = row_q;
    col_d     = col_q;
    base_d    = base_q;
    rd_pend_d = rd_pend_q;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = '0;
    adv_row   = 1'b0;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = tccw_pkg::CELL_RESET;
        if (sweep_last) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d   = S_DONE;
          rd_pend_d = 1'b0;
          case (func_i)
            tccw_pkg::FUNC_PUT: begin
              if (char_code_i == tccw_pkg::CHAR_NEWLINE) begin
                col_d   = '0;
                adv_row = 1'b1;
              end else if (char_code_i == tccw_pkg::CHAR_RETURN) begin
                col_d = '0;
              end else if (char_code_i == tccw_pkg::CHAR_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d     = col_q - 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr - 1'b1;
                end
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {attr_q, char_code_i};
                if (col_q == CW'(Cols - 1)) begin
                  col_d   = '0;
                  adv_row = 1'b1;
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
            tccw_pkg::FUNC_CLEAR: begin
              state_d = S_CLEAR;
              sweep_d = '0;
              row_d   = '0;
              col_d   = '0;
              base_d  = '0;
            end
            tccw_pkg::FUNC_READ: begin
              if (32'(cell_index_i) < 32'(Cells)) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(cell_index_i);
                rd_pend_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (adv_row) begin
            if (row_q == RW'(Rows - 1)) begin
              state_d   = S_SCROLL;
              sweep_d   = '0;
              mem_re    = 1'b1;
              mem_raddr = AW'(Cols);
              row_d     = RW'(Rows - 1);
              base_d    = AW'((Rows - 1) * Cols);
            end else begin
              row_d  = row_q + 1'b1;
              base_d = base_q + AW'(Cols);
            end
          end
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_last) begin
          sweep_d = '0;
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_q < AW'(Cells - Cols)) begin
          mem_wdata = mem_rdata_q;
        end
        if (scroll_next < (AW + 1)'(Cells)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(scroll_next);
        end
        if (sweep_last) begin
          sweep_d = '0;
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      attr_q      <= tccw_pkg::ATTR_RESET;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      row_q     <= row_d;
      col_q     <= col_d;
      base_q    <= base_d;
      rd_pend_q <= rd_pend_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_value_q <= rd_pend_q ? mem_rdata_q : 16'd0;
      out_row_q   <= 5'(row_q);
      out_col_q   <= 7'(col_q);
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_value_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

endmodule

>>> tb/text_console_cell_writer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console cell writer, predicting every beat.
module text_console_cell_writer_top_tb;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int LONG_HOLD = 80;
  localparam int PHASE_ITEMS = 85;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_result_t;

  class console_scoreboard;
    logic [15:0] screen [CELLS];
    int unsigned row;
    int unsigned col;
    logic [7:0] attr;
    console_result_t queued_results [$];
    int errors;

    function new();
      foreach (screen[k]) screen[k] = tccw_pkg::CELL_RESET;
      row = 0;
      col = 0;
      attr = tccw_pkg::ATTR_RESET;
      errors = 0;
    endfunction

    function void set_attribute(logic [7:0] a);
      attr = a;
    endfunction

    // Moving past the last row scrolls everything up and blanks the bottom row.
    function void next_line();
      col = 0;
      row++;
      if (row >= ROWS) begin
        for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
        for (int k = CELLS - COLS; k < CELLS; k++) screen[k] = {attr, tccw_pkg::CHAR_SPACE};
        row = ROWS - 1;
      end
    endfunction

    function void note_input(logic [1:0] func, logic [7:0] ch, logic [10:0] idx);
      console_result_t r;
      r.value = '0;
      case (func)
        tccw_pkg::FUNC_PUT: begin
          if (ch == tccw_pkg::CHAR_NEWLINE) begin
            next_line();
          end else if (ch == tccw_pkg::CHAR_RETURN) begin
            col = 0;
          end else if (ch == tccw_pkg::CHAR_BACKSPACE) begin
            if (col > 0) begin
              col--;
              screen[row * COLS + col] = {attr, tccw_pkg::CHAR_SPACE};
            end
          end else begin
            screen[row * COLS + col] = {attr, ch};
            col++;
            if (col >= COLS) next_line();
          end
        end
        tccw_pkg::FUNC_CLEAR: begin
          foreach (screen[k]) screen[k] = {attr, tccw_pkg::CHAR_SPACE};
          row = 0;
          col = 0;
        end
        tccw_pkg::FUNC_READ: begin
          if (idx < CELLS) r.value = screen[idx];
        end
        default: ;
      endcase
      r.row = row[4:0];
      r.col = col[6:0];
      queued_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] value, logic [4:0] r_row, logic [6:0] r_col);
      console_result_t want;
      if (queued_results.size() == 0) begin
        $display("%0t: result beat with none expected: cell %h row %0d col %0d",
                 $time, value, r_row, r_col);
        errors++;
        return;
      end
      want = queued_results.pop_front();
      if (value !== want.value) begin
        $display("%0t: cell_value expected %h actual %h", $time, want.value, value);
        errors++;
      end
      if (r_row !== want.row) begin
        $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, r_row);
        errors++;
      end
      if (r_col !== want.col) begin
        $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, r_col);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = tccw_pkg::FUNC_PUT;
  logic [7:0]  char_code_i = '0;
  logic [10:0] cell_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] cell_value_o;
  logic [4:0]  cursor_row_o;
  logic [6:0]  cursor_col_o;

  console_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  text_console_cell_writer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall_i <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(cell_value_o, cursor_row_o, cursor_col_o);
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] func, logic [7:0] ch, logic [10:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    char_code_i <= ch;
    cell_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(func, ch, idx);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.queued_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic begin_phase(logic [7:0] attr, int send_pct, int recv_pct);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= attr;
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
    @(posedge clk_i);
    board.set_attribute(attr);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly text lines, newline runs deep enough to scroll, reads near the
  // cursor and edits with backspace; the rest is clears and the unused code.
  task automatic run_random(int count);
    int stop_at;
    int kind;
    int len;
    int pick;
    logic [10:0] idx;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        len = ($urandom_range(99) < 20) ? $urandom_range(60, 85) : $urandom_range(0, 20);
        repeat (len)
          send_item(tccw_pkg::FUNC_PUT, 8'($urandom_range(255)), 11'($urandom_range(2047)));
        send_item(tccw_pkg::FUNC_PUT,
                  ($urandom_range(99) < 70) ? tccw_pkg::CHAR_NEWLINE : tccw_pkg::CHAR_RETURN,
                  11'($urandom_range(2047)));
      end else if (kind < 55) begin
        repeat ($urandom_range(1, 16))
          send_item(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_NEWLINE, 11'($urandom_range(2047)));
      end else if (kind < 72) begin
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(99);
          if (pick < 50) idx = 11'(board.row * COLS + $urandom_range(COLS - 1));
          else if (pick < 85) idx = 11'($urandom_range(CELLS - 1));
          else idx = 11'($urandom_range(2047));
          send_item(tccw_pkg::FUNC_READ, 8'($urandom_range(255)), idx);
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 6))
          send_item(tccw_pkg::FUNC_PUT, 8'($urandom_range(255)), 11'($urandom_range(2047)));
        repeat ($urandom_range(1, 8))
          send_item(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_BACKSPACE, 11'($urandom_range(2047)));
      end else if (kind < 96) begin
        send_item(FUNC_UNUSED, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end else begin
        send_item(tccw_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    // Directed beats with the reset attribute.
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 1));
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'(CELLS));
    send_item(tccw_pkg::FUNC_READ, 8'hFF, 11'h7FF);
    send_item(FUNC_UNUSED, 8'hFF, 11'h7FF);
    send_item(tccw_pkg::FUNC_PUT, 8'h00, 11'd0);
    send_item(tccw_pkg::FUNC_PUT, 8'hFF, 11'd0);
    send_item(tccw_pkg::FUNC_PUT, 8'h41, 11'd0);
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'd2);
    send_item(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_BACKSPACE, 11'd0);
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'd2);
    send_item(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_RETURN, 11'd0);
    send_item(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_BACKSPACE, 11'd0);
    send_item(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_NEWLINE, 11'd0);
    send_item(tccw_pkg::FUNC_PUT, 8'h7E, 11'd0);
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'(COLS));
    send_item(tccw_pkg::FUNC_CLEAR, 8'h00, 11'd0);
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'(COLS));
    send_item(tccw_pkg::FUNC_READ, 8'h00, 11'd0);
    run_random(PHASE_ITEMS);

    begin_phase(8'h00, 62, 0);
    run_random(PHASE_ITEMS);

    begin_phase(8'hFF, 0, 62);
    run_random(PHASE_ITEMS);

    begin_phase(8'($urandom_range(1, 254)), 38, 38);
    run_random(PHASE_ITEMS / 2);
    drain_results();
    run_random(PHASE_ITEMS / 2);

    begin_phase(8'($urandom_range(1, 254)), 0, 0);
    hold_requests <= hold_requests + 1;
    run_random(PHASE_ITEMS);

    begin_phase(tccw_pkg::ATTR_RESET, 38, 38);
    run_random(PHASE_ITEMS);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
